@@ src/ttsp_pkg.sv @@
// Shared types and constants for the transposition table store/probe block.
// Used by the lookup/decision stage and by the top level. No dependencies.
package ttsp_pkg;

    localparam int INDEX_BITS = 16;
    localparam int MOVE_BITS  = 16;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 7;
    localparam int FMOVE_W = 16;
    localparam int SCORE_W = 32;
    localparam int TICK_W  = 32;
    localparam int KIND_W  = 2;
    localparam int REQ_W   = 3;
    // stored depth minus a signed tick difference
    localparam int REL_W   = 34;
    localparam int MOVE_EXT = (MOVE_BITS > FMOVE_W) ? MOVE_BITS : FMOVE_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_STORE     = 3'd0,
        REQ_FORCE     = 3'd1,
        REQ_PROBE     = 3'd2,
        REQ_TICK_FWD  = 3'd3,
        REQ_TICK_BACK = 3'd4
    } t_req_code;

    // stored bound kinds
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd3;
    // requested kind code that a plain store rejects
    localparam logic [KIND_W-1:0] IN_KIND_BAD = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [KEY_W-1:0]     key;
        logic [DEPTH_W-1:0]   depth;
        logic [MOVE_BITS-1:0] move;
        logic [SCORE_W-1:0]   score;
        logic [TICK_W-1:0]    tick;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [KEY_W-1:0]   hash_key;
        logic [DEPTH_W-1:0] depth;
        logic [FMOVE_W-1:0] move;
        logic [SCORE_W-1:0] score;
        logic [KIND_W-1:0]  kind;
        logic [SCORE_W-1:0] alpha;
        logic [SCORE_W-1:0] beta;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic               deep_enough;
        logic               verdict;
        logic [SCORE_W-1:0] result_score;
        logic [SCORE_W-1:0] new_alpha;
        logic [SCORE_W-1:0] new_beta;
        logic [FMOVE_W-1:0] found_move;
        logic [KIND_W-1:0]  found_kind;
        logic               written;
    } t_result;

endpackage

@@ src/transposition_table_store_probe_top.sv @@
// Top level of the transposition table: control sequencer, tick counter,
// entry RAM and result register. Depends on ttsp_pkg, ttsp_ram, ttsp_eval.
//
// Each request (store, forced exact store, probe, tick step) is taken at the
// edge where start is high and busy is low. The entry RAM registers the
// indexed entry, the lookup stage registers it with its relative depth and
// its score comparisons against the window bounds, the decision state
// compares relative depth and writes the entry back, and the result word is
// shown on the o_ ports with o_strobe high for the cycle after that. busy
// stays high until then, so a new request cannot be taken before the last
// is through; it can be given in the strobe cycle. Results cannot be held
// off: sample them in the strobe cycle. After reset the table is cleared one
// entry a cycle, all 2^INDEX_BITS (65536) entries, with busy high throughout.
module transposition_table_store_probe_top import ttsp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [REQ_W-1:0]          i_req_type,
    input  logic [KEY_W-1:0]          i_hash_key,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic [FMOVE_W-1:0]        i_best_move,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [KIND_W-1:0]         i_entry_kind,
    input  logic signed [SCORE_W-1:0] i_alpha,
    input  logic signed [SCORE_W-1:0] i_beta,
    output logic                      o_strobe,
    output logic                      o_hit,
    output logic                      o_deep_enough,
    output logic                      o_verdict,
    output logic signed [SCORE_W-1:0] o_result_score,
    output logic signed [SCORE_W-1:0] o_new_alpha,
    output logic signed [SCORE_W-1:0] o_new_beta,
    output logic [FMOVE_W-1:0]        o_found_move,
    output logic [KIND_W-1:0]         o_found_kind,
    output logic                      o_written
);

    t_state                r_state;
    t_state                n_state;
    logic [INDEX_BITS-1:0] r_clr_idx;
    logic [TICK_W-1:0]     r_tick;
    logic [TICK_W-1:0]     n_tick;
    t_req                  r_req;
    t_result               r_res;
    logic                  r_strobe;

    logic                  accept;
    logic                  look;
    logic                  commit;
    logic                  ram_en;
    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_addr;
    t_entry                ram_wdata;
    t_entry                rd_entry;
    t_entry                new_entry;
    t_result               res;
    logic [MOVE_EXT-1:0]   move_ext;

    assign accept = start && (r_state == S_IDLE);

    ttsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rd_entry)
    );

    ttsp_eval u_eval (
        .i_clk   (i_clk),
        .i_look  (look),
        .i_req   (r_req),
        .i_entry (rd_entry),
        .i_tick  (r_tick),
        .o_res   (res)
    );

    // entry image for a write-back
    assign move_ext = MOVE_EXT'(r_req.move);
    always_comb begin
        new_entry.kind  = (r_req.req_type == REQ_FORCE) ? KIND_EXACT
                                                        : r_req.kind + KIND_W'(1);
        new_entry.key   = r_req.hash_key;
        new_entry.depth = r_req.depth;
        new_entry.move  = move_ext[MOVE_BITS-1:0];
        new_entry.score = r_req.score;
        new_entry.tick  = r_tick;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        look      = 1'b0;
        commit    = 1'b0;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = i_hash_key[INDEX_BITS-1:0];
        ram_wdata = new_entry;
        case (r_state)
            S_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_clr_idx;
                ram_wdata = '0;
            end
            S_IDLE: begin
                busy   = 1'b0;
                ram_en = start;
            end
            S_LOOK: begin
                look = 1'b1;
            end
            S_DECIDE: begin
                commit   = 1'b1;
                ram_en   = res.written;
                ram_we   = res.written;
                ram_addr = r_req.hash_key[INDEX_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_tick = r_tick;
        if (commit) begin
            case (r_req.req_type)
                REQ_TICK_FWD:  n_tick = r_tick + TICK_W'(1);
                REQ_TICK_BACK: n_tick = r_tick - TICK_W'(1);
                default:       n_tick = r_tick;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_tick    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tick   <= n_tick;
            r_strobe <= commit;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + INDEX_BITS'(1);
            end
        end
    end

    // request and result words carry no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.req_type <= i_req_type;
            r_req.hash_key <= i_hash_key;
            r_req.depth    <= i_search_depth;
            r_req.move     <= i_best_move;
            r_req.score    <= i_score;
            r_req.kind     <= i_entry_kind;
            r_req.alpha    <= i_alpha;
            r_req.beta     <= i_beta;
        end
        if (commit) begin
            r_res <= res;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_hit          = r_res.hit;
    assign o_deep_enough  = r_res.deep_enough;
    assign o_verdict      = r_res.verdict;
    assign o_result_score = $signed(r_res.result_score);
    assign o_new_alpha    = $signed(r_res.new_alpha);
    assign o_new_beta     = $signed(r_res.new_beta);
    assign o_found_move   = r_res.found_move;
    assign o_found_kind   = r_res.found_kind;
    assign o_written      = r_res.written;

    a_strobe_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == S_DECIDE)
        else $error("result strobe without a decision cycle");

    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_strobe)
        else $error("accepted request produced no result");

    a_verdict_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_verdict) |-> (o_hit && o_deep_enough && !o_written))
        else $error("verdict without a deep enough hit");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("busy while a result is shown");

endmodule

@@ src/ttsp_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module ttsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/ttsp_eval.sv @@
// Lookup stage registers and replace/probe decision for one table entry.
// Depends on ttsp_pkg.
module ttsp_eval import ttsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_look,
    input  t_req              i_req,
    input  t_entry            i_entry,
    input  logic [TICK_W-1:0] i_tick,
    output t_result           o_res
);

    logic [TICK_W-1:0]       diff;
    logic signed [REL_W-1:0] n_rel;
    logic signed [REL_W-1:0] r_rel;
    logic                    r_valid;
    logic                    r_key_eq;
    logic                    r_s_ge_b;
    logic                    r_s_gt_a;
    logic                    r_s_le_a;
    logic                    r_s_lt_b;
    logic [SCORE_W-1:0]      r_s_m1;
    logic [SCORE_W-1:0]      r_s_p1;
    logic [KIND_W-1:0]       r_kind;
    logic [SCORE_W-1:0]      r_score;
    logic [MOVE_BITS-1:0]    r_move;
    logic signed [REL_W-1:0] req_depth;
    logic                    rel_ge;
    logic                    rel_le;
    logic [MOVE_EXT-1:0]     move_ext;

    assign diff  = i_tick - i_entry.tick;
    assign n_rel = $signed({{(REL_W-DEPTH_W){1'b0}}, i_entry.depth})
                 - $signed({{(REL_W-TICK_W){diff[TICK_W-1]}}, diff});

    // capture the entry, its relative depth and the score comparisons while look is high
    always_ff @(posedge i_clk) begin
        if (i_look) begin
            r_rel    <= n_rel;
            r_valid  <= (i_entry.kind != KIND_EMPTY);
            r_key_eq <= (i_entry.key == i_req.hash_key);
            r_s_ge_b <= ($signed(i_entry.score) >= $signed(i_req.beta));
            r_s_gt_a <= ($signed(i_entry.score) >  $signed(i_req.alpha));
            r_s_le_a <= ($signed(i_entry.score) <= $signed(i_req.alpha));
            r_s_lt_b <= ($signed(i_entry.score) <  $signed(i_req.beta));
            r_s_m1   <= i_entry.score - SCORE_W'(1);
            r_s_p1   <= i_entry.score + SCORE_W'(1);
            r_kind   <= i_entry.kind;
            r_score  <= i_entry.score;
            r_move   <= i_entry.move;
        end
    end

    assign req_depth = $signed({{(REL_W-DEPTH_W){1'b0}}, i_req.depth});
    assign rel_ge    = (r_rel >= req_depth);
    assign rel_le    = (r_rel <= req_depth);
    assign move_ext  = MOVE_EXT'(r_move);

    always_comb begin
        o_res = '0;
        case (i_req.req_type)
            REQ_STORE: begin
                o_res.written = (i_req.kind != IN_KIND_BAD) && (!r_valid || rel_le);
            end
            REQ_FORCE: begin
                o_res.written = 1'b1;
            end
            REQ_PROBE: begin
                o_res.new_alpha = i_req.alpha;
                o_res.new_beta  = i_req.beta;
                if (r_valid && r_key_eq) begin
                    o_res.hit          = 1'b1;
                    o_res.result_score = r_score;
                    o_res.found_move   = move_ext[FMOVE_W-1:0];
                    o_res.found_kind   = r_kind;
                    if (rel_ge) begin
                        o_res.deep_enough = 1'b1;
                        case (r_kind)
                            KIND_EXACT: begin
                                o_res.verdict = 1'b1;
                            end
                            KIND_LOWER: begin
                                if (r_s_ge_b) begin
                                    o_res.verdict = 1'b1;
                                end else if (r_s_gt_a) begin
                                    o_res.new_alpha = r_s_m1;
                                end
                            end
                            KIND_UPPER: begin
                                if (r_s_le_a) begin
                                    o_res.verdict = 1'b1;
                                end else if (r_s_lt_b) begin
                                    o_res.new_beta = r_s_p1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule
